// File: hw/rtl/bth_alloc_pkg.sv
// shared codes and limits for the boundary tag heap allocator
`timescale 1ns / 1ps
package bth_alloc_pkg;

  localparam int REQ_W  = 28;
  localparam int OFF_W  = 15;
  localparam int STAT_W = 2;
  localparam int FUNC_W = 2;
  localparam int ABYTES_W = 16;

  localparam logic [REQ_W-1:0] SIZE_LIMIT = 28'h8000000;

  localparam logic [FUNC_W-1:0] FN_ALLOC   = 2'd0;
  localparam logic [FUNC_W-1:0] FN_RELEASE = 2'd1;
  localparam logic [FUNC_W-1:0] FN_COMPACT = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
  localparam logic [STAT_W-1:0] ST_SIZE    = 2'd1;
  localparam logic [STAT_W-1:0] ST_NOROOM  = 2'd2;
  localparam logic [STAT_W-1:0] ST_BADADDR = 2'd3;

endpackage

// File: hw/rtl/boundary_tag_heap_allocator_unit.sv
// boundary tag heap allocator with header walk sequencer and header memory
//
// channel  dir  signals                         contents
// s        in   s_tvalid s_tready s_tdata s_tuser  request transaction
// m        out  m_tvalid m_tready m_tdata m_tuser  result transaction
//
// release reads the block header and writes it back free; a size error goes straight to the result hand-over.
// allocate walks the block headers for an exact fit, then tries the free pointer, then runs a merge
// walk that joins free neighbours, and splits the chosen block when it is larger than the request.
// compact runs the merge walk over the block headers; all walks share one memory read port.
// after reset a clearing pass writes the header memory; no request is taken until it ends.
// a stalled result does not block the next request.
`timescale 1ns / 1ps
module boundary_tag_heap_allocator_unit
  import bth_alloc_pkg::*;
#(
  parameter int HEAP_UNITS = 4096,
  parameter int UNIT_BYTES = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // request_bytes[27:0], release_offset[42:28], zero fill
  input  logic [1:0]  s_tuser,   // func[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // payload_offset[14:0], allocated_bytes[30:15], zero fill
  output logic [1:0]  m_tuser    // status[1:0]
);

  localparam int AW  = $clog2(HEAP_UNITS);
  localparam int HW  = AW + 1;
  localparam int UBW = $clog2(UNIT_BYTES + 1);
  localparam int PW  = AW + 1 + UBW;
  localparam int BW  = AW + UBW;

  typedef enum logic [3:0] {
    CLEAR, IDLE, EX_RD, EX_CHK, FP_RD, FP_CHK, M_RD, M_CHK, M_WR,
    SPLIT, SPLIT2, REL_RD, REL_CHK, DONE
  } state_t;

  state_t state;

  logic [HW-1:0] mem [HEAP_UNITS];
  logic [HW-1:0] rdata;
  logic [AW-1:0] clr;
  logic [AW:0]   at;
  logic [REQ_W-1:0] need;
  logic [AW-1:0] bsize;
  logic [AW-1:0] best;
  logic          have_run;
  logic          compact;
  logic [AW-1:0] fp;
  logic          fpv;
  logic [AW-1:0] total;
  logic [OFF_W-1:0] rel_idx;
  logic [STAT_W-1:0] status;
  logic [OFF_W-1:0]  payload;

  logic [AW-1:0] rsz;
  logic          rused;
  logic [AW-1:0] need_a;
  logic [REQ_W-1:0] in_bytes;
  logic [OFF_W-1:0] in_off;
  logic [REQ_W:0]   need_full;
  logic [OFF_W-1:0] rel_q;
  logic [OFF_W-1:0] rel_r;
  logic [OFF_W-1:0] rel_i;
  logic             rel_bad;
  logic [AW-1:0]    pay_base;
  logic [PW-1:0]    pay_full;
  logic [BW-1:0]    tot_bytes;
  logic [ABYTES_W-1:0] out_bytes;
  logic [AW-1:0]    msum;

  assign rsz      = rdata[AW-1:0];
  assign rused    = rdata[AW];
  assign need_a   = need[AW-1:0];
  assign in_bytes = s_tdata[27:0];
  assign in_off   = s_tdata[42:28];
  assign need_full = (REQ_W+1)'(((REQ_W+1)'(in_bytes) + (REQ_W+1)'(2 * UNIT_BYTES - 1))
                                / UNIT_BYTES);
  assign rel_q    = OFF_W'(in_off / UNIT_BYTES);
  assign rel_r    = OFF_W'(in_off % UNIT_BYTES);
  assign rel_i    = rel_q - 1'b1;
  assign rel_bad  = (in_off < UNIT_BYTES) || (rel_r != '0) || (rel_i >= HEAP_UNITS);
  assign pay_base = (state == EX_CHK) ? at[AW-1:0] : best;
  assign pay_full = (PW'(pay_base) + 1'b1) * PW'(UNIT_BYTES);
  assign tot_bytes = BW'(total) * BW'(UNIT_BYTES);
  assign out_bytes = ((total > 16'hFFFF) || (tot_bytes > 16'hFFFF)) ? 16'hFFFF
                                                                   : ABYTES_W'(tot_bytes);
  assign msum     = bsize + rsz;
  assign s_tready = (state == IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= CLEAR;
      clr      <= '0;
      fp       <= '0;
      fpv      <= 1'b1;
      total    <= '0;
      m_tvalid <= 1'b0;
      have_run <= 1'b0;
      compact  <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && (state != DONE)) m_tvalid <= 1'b0;
      unique case (state)
        CLEAR: begin
          mem[clr] <= (clr == '0) ? HW'(HEAP_UNITS - 1) : '0;
          clr <= clr + 1'b1;
          if (clr == AW'(HEAP_UNITS - 1)) state <= IDLE;
        end
        IDLE: begin
          if (s_tvalid) begin
            status   <= ST_OK;
            payload  <= '0;
            at       <= '0;
            have_run <= 1'b0;
            compact  <= 1'b0;
            priority if (s_tuser == FN_ALLOC) begin
              if ((in_bytes == '0) || (in_bytes >= SIZE_LIMIT)) begin
                status <= ST_SIZE;
                state  <= DONE;
              end else begin
                need  <= REQ_W'(need_full);
                state <= EX_RD;
              end
            end else if (s_tuser == FN_RELEASE) begin
              rel_idx <= rel_i;
              if (rel_bad) begin
                status <= ST_BADADDR;
                state  <= DONE;
              end else begin
                state <= REL_RD;
              end
            end else if (s_tuser == FN_COMPACT) begin
              compact <= 1'b1;
              state   <= M_RD;
            end else begin
              state <= DONE;
            end
          end
        end
        EX_RD: begin
          if (at >= HEAP_UNITS) begin
            state <= FP_RD;
          end else begin
            rdata <= mem[at[AW-1:0]];
            state <= EX_CHK;
          end
        end
        EX_CHK: begin
          priority if (rsz == '0) begin
            state <= FP_RD;
          end else if (!rused && (REQ_W'(rsz) == need)) begin
            mem[at[AW-1:0]] <= {1'b1, rsz};
            if (fpv && (fp == at[AW-1:0])) fpv <= 1'b0;
            total   <= total + rsz;
            payload <= pay_full[OFF_W-1:0];
            state   <= DONE;
          end else begin
            at    <= at + (AW+1)'(rsz);
            state <= EX_RD;
          end
        end
        FP_RD: begin
          if (!fpv) begin
            at       <= '0;
            have_run <= 1'b0;
            state    <= M_RD;
          end else begin
            rdata <= mem[fp];
            state <= FP_CHK;
          end
        end
        FP_CHK: begin
          if (rused || (rsz == '0) || (need > REQ_W'(rsz))) begin
            if (rused || (rsz == '0)) fpv <= 1'b0;
            at       <= '0;
            have_run <= 1'b0;
            state    <= M_RD;
          end else begin
            best  <= fp;
            bsize <= rsz;
            state <= SPLIT;
          end
        end
        M_RD: begin
          if (at >= HEAP_UNITS) begin
            fp     <= '0;
            fpv    <= 1'b0;
            status <= compact ? ST_OK : ST_NOROOM;
            state  <= DONE;
          end else begin
            rdata <= mem[at[AW-1:0]];
            state <= M_CHK;
          end
        end
        M_CHK: begin
          at <= at + (AW+1)'(rsz);
          priority if (rsz == '0) begin
            fp     <= '0;
            fpv    <= 1'b0;
            status <= compact ? ST_OK : ST_NOROOM;
            state  <= DONE;
          end else if (rused) begin
            have_run <= 1'b0;
            state    <= M_RD;
          end else if (!have_run) begin
            best     <= at[AW-1:0];
            bsize    <= rsz;
            have_run <= 1'b1;
            if (!compact && (need <= REQ_W'(rsz))) begin
              fp    <= at[AW-1:0];
              fpv   <= 1'b1;
              state <= SPLIT;
            end else begin
              state <= M_RD;
            end
          end else begin
            // absorbed header is cleared, run head rewritten next cycle
            mem[at[AW-1:0]] <= '0;
            bsize <= msum;
            state <= M_WR;
          end
        end
        M_WR: begin
          mem[best] <= {1'b0, bsize};
          if (!compact && (need <= REQ_W'(bsize))) begin
            fp    <= best;
            fpv   <= 1'b1;
            state <= SPLIT;
          end else begin
            state <= M_RD;
          end
        end
        SPLIT: begin
          if (REQ_W'(bsize) > need) begin
            fp <= best + need_a;
            mem[best + need_a] <= {1'b0, bsize - need_a};
            state <= SPLIT2;
          end else begin
            fpv       <= 1'b0;
            mem[best] <= {1'b1, bsize};
            total     <= total + bsize;
            payload   <= pay_full[OFF_W-1:0];
            state     <= DONE;
          end
        end
        SPLIT2: begin
          mem[best] <= {1'b1, need_a};
          total     <= total + need_a;
          payload   <= pay_full[OFF_W-1:0];
          state     <= DONE;
        end
        REL_RD: begin
          rdata <= mem[AW'(rel_idx)];
          state <= REL_CHK;
        end
        REL_CHK: begin
          if (!rused) begin
            status <= ST_BADADDR;
          end else begin
            mem[AW'(rel_idx)] <= {1'b0, rsz};
            total <= (total >= rsz) ? total - rsz : '0;
          end
          state <= DONE;
        end
        DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tuser  <= status;
            m_tdata  <= {1'b0, out_bytes, payload};
            state    <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_start: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> (state != IDLE))
    else $error("accepted transaction did not start work");
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser != ST_OK)) |-> (m_tdata[14:0] == '0))
    else $error("failed transaction carries a payload offset");
  a_split_fits: assert property (@(posedge clk) disable iff (rst)
    (state == SPLIT) |-> (REQ_W'(bsize) >= need))
    else $error("split of a block smaller than the request");
  a_total_bound: assert property (@(posedge clk) disable iff (rst)
    (state == IDLE) |-> (total < HEAP_UNITS))
    else $error("allocated units exceed the heap");
`endif

endmodule
